[rtl/core/bole_pkg.sv]
// Package for the bounded ordered list engine: command codes, cell
// operations, sequencer states and field widths.
// No dependencies.
package bole_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int MODE_W  = 4;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int IDX_W   = 5;
   localparam int COUNT_W = 5;

   localparam logic [IDX_W-1:0] NO_INDEX = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND       = 4'd0,
      MODE_PREPEND      = 4'd1,
      MODE_INSERT       = 4'd2,
      MODE_POP_FIRST    = 4'd3,
      MODE_POP_LAST     = 4'd4,
      MODE_REMOVE_AT    = 4'd5,
      MODE_FIND         = 4'd6,
      MODE_APPEND_NEW   = 4'd7,
      MODE_REMOVE_MATCH = 4'd8,
      MODE_REMOVE_ALL   = 4'd9,
      MODE_CLEAR        = 4'd10
   } mode_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_MATCH,
      CELL_UP,
      CELL_DOWN
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

[rtl/core/bounded_ordered_list_engine_unit.sv]
// Bounded ordered list engine, top level: command sequencer and chain of cells.
// One request in, one response strobe out; the receiver cannot stall.
// Depends on bole_pkg and bole_cell.
//
// Timing: a request is taken when start is high and busy is low. Append,
// prepend, insert, the removes by position, clear and unused codes pass
// through the decide state and answer from the response state, in which
// the next request can already be taken. Find, append-if-absent and
// remove_first_match walk the cell chain one cell per cycle from the head
// up to the first match or the end of the list. remove_all always walks to
// the end of the list, removing matches on the way. All cells compare and
// shift in parallel, so inserts and removes at a given position need no
// walk. No clearing pass is needed after reset.
module bounded_ordered_list_engine_unit import bole_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      busy,
   output logic                      rsp_strobe,
   output logic                      rsp_ok,
   output logic signed [IDX_W-1:0]   rsp_found_index,
   output logic [COUNT_W-1:0]        rsp_element_count
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               any_ff, any_in;
   logic               ok_ff, ok_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   cell_op_type        cell_op;
   logic [IW-1:0]      cell_pos;
   logic [VALUE_W-1:0] cell_value;

   logic [VALUE_W-1:0] data_vec [CAPACITY];
   logic [CAPACITY-1:0] match_vec;

   logic          accept;
   logic          full, empty;
   logic [PW-1:0] cnt_w, pos_w, ptr_w;

   assign accept = req_start && !busy;
   assign full   = (count_ff == FULL_COUNT);
   assign empty  = (count_ff == '0);
   assign cnt_w  = PW'(count_ff);
   assign pos_w  = PW'(pos_ff);
   assign ptr_w  = PW'(ptr_ff);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_d, right_d;
      logic               right_m;
      if (g == 0) begin : g_head
         assign left_d = cell_value;
      end else begin : g_mid
         assign left_d = data_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_d = data_vec[g];
         assign right_m = match_vec[g];
      end else begin : g_body
         assign right_d = data_vec[g+1];
         assign right_m = match_vec[g+1];
      end
      bole_cell #(
         .IW    (IW),
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .op          (cell_op),
         .pos         (cell_pos),
         .value       (cell_value),
         .left_data   (left_d),
         .right_data  (right_d),
         .right_match (right_m),
         .data        (data_vec[g]),
         .match       (match_vec[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      ptr_ff   <= ptr_in;
      any_ff   <= any_in;
      ok_ff    <= ok_in;
      idx_ff   <= idx_in;
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      any_in     = any_ff;
      ok_in      = ok_ff;
      idx_in     = idx_ff;
      cell_op    = CELL_HOLD;
      cell_pos   = '0;
      cell_value = value_ff;

      case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               mode_in    = req_mode;
               value_in   = req_value;
               pos_in     = req_position;
               cell_op    = CELL_MATCH;
               cell_value = req_value;
               state_in   = ST_DECIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            ok_in    = 1'b0;
            idx_in   = NO_INDEX;
            ptr_in   = '0;
            any_in   = 1'b0;
            case (mode_ff)
               MODE_APPEND: begin
                  if (!full) begin
                     cell_op  = CELL_UP;
                     cell_pos = cnt_w[IW-1:0];
                     count_in = count_ff + 1'b1;
                     ok_in    = 1'b1;
                  end
               end
               MODE_PREPEND: begin
                  if (!full) begin
                     cell_op  = CELL_UP;
                     count_in = count_ff + 1'b1;
                     ok_in    = 1'b1;
                  end
               end
               MODE_INSERT: begin
                  if (!full && pos_w <= cnt_w) begin
                     cell_op  = CELL_UP;
                     cell_pos = pos_w[IW-1:0];
                     count_in = count_ff + 1'b1;
                     ok_in    = 1'b1;
                  end
               end
               MODE_POP_FIRST: begin
                  if (!empty) begin
                     cell_op  = CELL_DOWN;
                     count_in = count_ff - 1'b1;
                     ok_in    = 1'b1;
                  end
               end
               MODE_POP_LAST: begin
                  if (!empty) begin
                     count_in = count_ff - 1'b1;
                     ok_in    = 1'b1;
                  end
               end
               MODE_REMOVE_AT: begin
                  if (pos_w < cnt_w) begin
                     cell_op  = CELL_DOWN;
                     cell_pos = pos_w[IW-1:0];
                     count_in = count_ff - 1'b1;
                     ok_in    = 1'b1;
                  end
               end
               MODE_FIND, MODE_APPEND_NEW, MODE_REMOVE_MATCH, MODE_REMOVE_ALL: begin
                  state_in = ST_SCAN;
               end
               MODE_CLEAR: begin
                  count_in = '0;
                  ok_in    = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (ptr_ff >= count_ff) begin
               // end of list, no (further) match
               state_in = ST_RESP;
               case (mode_ff)
                  MODE_APPEND_NEW: begin
                     if (!full) begin
                        cell_op  = CELL_UP;
                        cell_pos = cnt_w[IW-1:0];
                        count_in = count_ff + 1'b1;
                        ok_in    = 1'b1;
                     end
                  end
                  MODE_REMOVE_ALL: begin
                     ok_in = any_ff;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end else if (match_vec[ptr_ff[IW-1:0]]) begin
               case (mode_ff)
                  MODE_FIND: begin
                     ok_in    = 1'b1;
                     idx_in   = ptr_w[IDX_W-1:0];
                     state_in = ST_RESP;
                  end
                  MODE_REMOVE_MATCH: begin
                     cell_op  = CELL_DOWN;
                     cell_pos = ptr_ff[IW-1:0];
                     count_in = count_ff - 1'b1;
                     ok_in    = 1'b1;
                     state_in = ST_RESP;
                  end
                  MODE_REMOVE_ALL: begin
                     // match flags shift with the data; recheck same slot
                     cell_op  = CELL_DOWN;
                     cell_pos = ptr_ff[IW-1:0];
                     count_in = count_ff - 1'b1;
                     any_in   = 1'b1;
                  end
                  default: begin
                     ok_in    = 1'b0;
                     state_in = ST_RESP;
                  end
               endcase
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign rsp_strobe        = (state_ff == ST_RESP);
   assign rsp_ok            = ok_ff;
   assign rsp_found_index   = idx_ff;
   assign rsp_element_count = cnt_w[COUNT_W-1:0];

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count above capacity");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_strobe)
      else $error("sequencer not busy after request");

   a_index_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found_index != NO_INDEX |-> rsp_ok)
      else $error("index reported without success");

   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> ptr_ff <= count_ff)
      else $error("scan pointer past end of list");

endmodule

[rtl/core/bole_cell.sv]
// One storage cell of the list chain: holds one element and its match flag.
// Shifts toward or away from its neighbors as the sequencer directs.
// Depends on bole_pkg.
module bole_cell import bole_pkg::*; #(
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  cell_op_type        op,
   input  logic [IW-1:0]      pos,
   input  logic [VALUE_W-1:0] value,
   input  logic [VALUE_W-1:0] left_data,
   input  logic [VALUE_W-1:0] right_data,
   input  logic               right_match,
   output logic [VALUE_W-1:0] data,
   output logic               match
);

   localparam logic [IW-1:0] HERE = IW'(INDEX);

   logic [VALUE_W-1:0] data_ff, data_in;
   logic               match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      case (op)
         CELL_MATCH: begin
            match_in = (data_ff == value);
         end
         CELL_UP: begin
            if (HERE > pos) begin
               data_in  = left_data;
               match_in = 1'b0;
            end else if (HERE == pos) begin
               data_in  = value;
               match_in = 1'b0;
            end
         end
         CELL_DOWN: begin
            if (HERE >= pos) begin
               data_in  = right_data;
               match_in = right_match;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

[tb/tb_bounded_ordered_list_engine_unit.sv]
`timescale 1ns / 1ps
// Testbench for bounded_ordered_list_engine_unit: directed and random list
// commands, each checked against a local model of the list and its count.
// Depends on bole_pkg and the engine RTL.
module tb_bounded_ordered_list_engine_unit;
   import bole_pkg::*;

   localparam int                CAP             = CAPACITY_DEFAULT;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 4'd11;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 4'd15;
   localparam int                IDLE_PERCENT    = 28;
   localparam int                STALL_LIMIT     = 2000;
   localparam int                TAIL_CYCLES     = 60;
   localparam int                PHASE_REQUESTS  = 120;

   typedef struct packed {
      logic                    ok;
      logic signed [IDX_W-1:0] idx;
      logic [COUNT_W-1:0]      cnt;
   } list_status_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_start = 1'b0;
   logic [MODE_W-1:0]         req_mode = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      busy;
   logic                      rsp_strobe;
   logic                      rsp_ok;
   logic signed [IDX_W-1:0]   rsp_found_index;
   logic [COUNT_W-1:0]        rsp_element_count;

   logic [VALUE_W-1:0] list_words [CAP];
   int                 list_count = 0;
   list_status_type    pending_status [$];
   list_status_type    head_status;
   logic [VALUE_W-1:0] value_pool [8];
   int                 error_count = 0;
   int                 stall_cycles = 0;
   bit                 idle_on = 1'b1;

   bounded_ordered_list_engine_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_start         (req_start),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_position      (req_position),
      .busy              (busy),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_found_index   (rsp_found_index),
      .rsp_element_count (rsp_element_count)
   );

   always #2 clock = ~clock;

   function automatic int find_word(input logic [VALUE_W-1:0] v);
      for (int i = 0; i < list_count; i++) begin
         if (list_words[i] == v) return i;
      end
      return -1;
   endfunction

   function automatic bit insert_word(input int pos, input logic [VALUE_W-1:0] v);
      if (list_count >= CAP || pos > list_count) return 1'b0;
      for (int i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
      list_words[pos] = v;
      list_count++;
      return 1'b1;
   endfunction

   function automatic bit remove_word(input int pos);
      if (list_count == 0 || pos >= list_count) return 1'b0;
      for (int i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
      list_count--;
      return 1'b1;
   endfunction

   function automatic list_status_type apply_list_command(input logic [MODE_W-1:0] mode,
                                                          input logic [VALUE_W-1:0] value,
                                                          input logic [POS_W-1:0] pos);
      list_status_type r;
      int              hit;
      r.ok  = 1'b0;
      r.idx = NO_INDEX;
      case (mode)
         MODE_APPEND:       r.ok = insert_word(list_count, value);
         MODE_PREPEND:      r.ok = insert_word(0, value);
         MODE_INSERT:       r.ok = insert_word(int'(pos), value);
         MODE_POP_FIRST:    r.ok = remove_word(0);
         MODE_POP_LAST:     r.ok = (list_count != 0) && remove_word(list_count - 1);
         MODE_REMOVE_AT:    r.ok = remove_word(int'(pos));
         MODE_FIND: begin
            hit = find_word(value);
            if (hit >= 0) begin
               r.ok  = 1'b1;
               r.idx = hit[IDX_W-1:0];
            end
         end
         MODE_APPEND_NEW:   r.ok = (find_word(value) < 0) && insert_word(list_count, value);
         MODE_REMOVE_MATCH: begin
            hit = find_word(value);
            if (hit >= 0) r.ok = remove_word(hit);
         end
         MODE_REMOVE_ALL: begin
            hit  = find_word(value);
            r.ok = (hit >= 0);
            while (hit >= 0) begin
               void'(remove_word(hit));
               hit = find_word(value);
            end
         end
         MODE_CLEAR: begin
            list_count = 0;
            r.ok       = 1'b1;
         end
         default: ;
      endcase
      r.cnt = list_count[COUNT_W-1:0];
      return r;
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_start    <= 1'b1;
      req_mode     <= mode;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (busy);
      pending_status.push_back(apply_list_command(mode, value, pos));
   endtask

   task automatic wait_until_drained();
      req_start <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   task automatic test_edge_cases();
      send_request(MODE_POP_FIRST, 32'd0, 5'd0);
      send_request(MODE_POP_LAST, 32'd0, 5'd0);
      send_request(MODE_REMOVE_AT, 32'd0, 5'd0);
      send_request(MODE_FIND, 32'd0, 5'd0);
      send_request(MODE_REMOVE_ALL, 32'd0, 5'd0);
      send_request(MODE_APPEND, 32'h7fff_ffff, 5'd0);
      send_request(MODE_APPEND, 32'h8000_0000, 5'd31);
      send_request(MODE_PREPEND, 32'h0000_0000, 5'd0);
      send_request(MODE_INSERT, 32'hffff_ffff, 5'd3);
      send_request(MODE_INSERT, 32'h1234_5678, 5'd5);
      send_request(MODE_INSERT, 32'h1234_5678, 5'd31);
      send_request(MODE_FIND, 32'h8000_0000, 5'd0);
      send_request(MODE_FIND, 32'h1234_5678, 5'd0);
      send_request(MODE_APPEND_NEW, 32'h0000_0000, 5'd0);
      send_request(MODE_APPEND_NEW, 32'h0000_0005, 5'd0);
      send_request(MODE_REMOVE_AT, 32'd0, 5'd5);
      send_request(MODE_REMOVE_AT, 32'd0, 5'd31);
      send_request(MODE_REMOVE_AT, 32'd0, 5'd1);
      send_request(MODE_REMOVE_MATCH, 32'h1234_5678, 5'd0);
      send_request(MODE_REMOVE_MATCH, 32'hffff_ffff, 5'd0);
      send_request(MODE_PREPEND, 32'h0000_0005, 5'd0);
      send_request(MODE_REMOVE_ALL, 32'h0000_0005, 5'd0);
      send_request(MODE_REMOVE_ALL, 32'h0000_0005, 5'd0);
      send_request(MODE_UNUSED_LO, 32'hffff_ffff, 5'd31);
      send_request(MODE_UNUSED_HI, 32'd0, 5'd0);
      send_request(MODE_CLEAR, 32'd0, 5'd0);
   endtask

   task automatic test_full_list();
      send_request(MODE_CLEAR, $urandom, 5'($urandom));
      repeat (CAP) send_request(MODE_APPEND, $urandom, 5'($urandom));
      send_request(MODE_APPEND, $urandom, 5'd0);
      send_request(MODE_PREPEND, $urandom, 5'd0);
      send_request(MODE_INSERT, $urandom, 5'd0);
      send_request(MODE_APPEND_NEW, $urandom, 5'd0);
      send_request(MODE_FIND, list_words[CAP-1], 5'd0);
      send_request(MODE_REMOVE_AT, 32'd0, 5'(CAP - 1));
      send_request(MODE_INSERT, 32'h8000_0000, 5'(CAP - 1));
      send_request(MODE_APPEND_NEW, 32'h8000_0000, 5'd0);
   endtask

   task automatic test_random_sequences();
      int                 grow_pct [5] = '{75, 50, 30, 65, 45};
      int                 r;
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
      for (int phase = 0; phase < 5; phase++) begin
         idle_on = (phase != 3);
         repeat (PHASE_REQUESTS) begin
            r = $urandom_range(99);
            if (r < grow_pct[phase]) begin
               case ($urandom_range(3))
                  0: mode = MODE_APPEND;
                  1: mode = MODE_PREPEND;
                  2: mode = MODE_INSERT;
                  default: mode = MODE_APPEND_NEW;
               endcase
            end else if (r < 90) begin
               case ($urandom_range(6))
                  0: mode = MODE_POP_FIRST;
                  1: mode = MODE_POP_LAST;
                  2: mode = MODE_REMOVE_AT;
                  3: mode = MODE_REMOVE_MATCH;
                  4: mode = MODE_REMOVE_ALL;
                  default: mode = MODE_FIND;
               endcase
            end else if (r < 97) begin
               mode = MODE_FIND;
            end else if (r < 99) begin
               mode = MODE_CLEAR;
            end else begin
               mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            end
            value = ($urandom_range(3) != 0) ? value_pool[$urandom_range(7)] : $urandom;
            pos   = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                             : 5'($urandom_range(list_count));
            send_request(mode, value, pos);
         end
         wait_until_drained();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_status.size() == 0) begin
            $display("%0t: unexpected response ok=%0b idx=%0d count=%0d", $time,
                     rsp_ok, rsp_found_index, rsp_element_count);
            error_count++;
         end else begin
            head_status = pending_status.pop_front();
            if (rsp_ok !== head_status.ok) begin
               $display("%0t: ok mismatch exp %0b got %0b", $time, head_status.ok, rsp_ok);
               error_count++;
            end
            if (rsp_found_index !== head_status.idx) begin
               $display("%0t: found_index mismatch exp %0d got %0d", $time,
                        head_status.idx, rsp_found_index);
               error_count++;
            end
            if (rsp_element_count !== head_status.cnt) begin
               $display("%0t: element_count mismatch exp %0d got %0d", $time,
                        head_status.cnt, rsp_element_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (req_start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no progress", $time);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      wait_until_drained();
      test_full_list();
      test_random_sequences();
      req_start <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_status.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[bounded_ordered_list_engine_unit.f]
rtl/core/bole_pkg.sv
rtl/core/bole_cell.sv
rtl/core/bounded_ordered_list_engine_unit.sv
tb/tb_bounded_ordered_list_engine_unit.sv
